// ----- src/gcm_pkg.sv -----
package gcm_pkg;

  // Default amount width
  localparam int AMOUNT_BITS_DEF = 24;

  // Fixed field widths
  localparam int DENOM_BITS = 16;
  localparam int COUNT_BITS = 24;

  // Remainder after the lead division stays below 50000
  localparam int REST_BITS = 16;
  // Uncorrected remainder stays below twice the lead denomination
  localparam int REM_BITS = 17;

  // Reciprocal multiply for the lead division
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_BITS = 25;

  localparam logic [DENOM_BITS-1:0] LEAD_SMALL = DENOM_BITS'(200);
  localparam logic [DENOM_BITS-1:0] LEAD_FULL = DENOM_BITS'(50000);

  localparam logic [RECIP_BITS-1:0] RECIP_SMALL =
    RECIP_BITS'((64'd1 << RECIP_SHIFT) / 200);
  localparam logic [RECIP_BITS-1:0] RECIP_FULL =
    RECIP_BITS'((64'd1 << RECIP_SHIFT) / 50000);

  // Compare cells after the lead division, largest first
  localparam int CHAIN_CELLS = 14;
  localparam int unsigned CHAIN_DENOM [CHAIN_CELLS] = '{
    20000, 10000, 5000, 2000, 1000, 500, 200, 100, 50, 20, 10, 5, 2, 1
  };

  // Denomination set select
  typedef enum logic {
    SET_COINS = 1'b0,
    SET_FULL  = 1'b1
  } coin_set_t;

  // One result as produced by a stage
  typedef struct packed {
    logic                  strobe;
    logic [DENOM_BITS-1:0] denom;
    logic [COUNT_BITS-1:0] count;
    logic                  last;
  } result_t;

endpackage

// ----- src/gcm_lead_div.sv -----
module gcm_lead_div #(
  parameter int AMOUNT_BITS = gcm_pkg::AMOUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic [AMOUNT_BITS-1:0]               amount,
  input  gcm_pkg::coin_set_t                   coin_set,
  output logic                                 active,
  output logic                                 rest_vld,
  output logic [gcm_pkg::REST_BITS-1:0]        rest,
  output gcm_pkg::result_t                     res
);

  localparam int PROD_BITS = AMOUNT_BITS + gcm_pkg::RECIP_BITS;

  // Stage 1: captured amount
  logic                   v1;
  logic [AMOUNT_BITS-1:0] amt1;
  gcm_pkg::coin_set_t     set1;

  // Stage 2: estimated quotient
  logic                   v2;
  logic [AMOUNT_BITS-1:0] amt2;
  logic [AMOUNT_BITS-1:0] q0_2;
  gcm_pkg::coin_set_t     set2;

  // Stage 3: estimated quotient and raw remainder
  logic                           v3;
  logic [AMOUNT_BITS-1:0]         q0_3;
  logic [gcm_pkg::REM_BITS-1:0]   r0_3;
  gcm_pkg::coin_set_t             set3;

  logic [gcm_pkg::RECIP_BITS-1:0] recip1;
  logic [PROD_BITS-1:0]           prod;
  logic [gcm_pkg::DENOM_BITS-1:0] d2;
  logic [gcm_pkg::DENOM_BITS-1:0] d3;
  logic [AMOUNT_BITS-1:0]         qd;
  logic                           corr;
  logic [AMOUNT_BITS-1:0]         q;
  logic [gcm_pkg::REM_BITS-1:0]   r;

  // Reciprocal and denomination per set
  always_comb begin
    recip1 = (set1 == gcm_pkg::SET_FULL) ? gcm_pkg::RECIP_FULL : gcm_pkg::RECIP_SMALL;
    d2     = (set2 == gcm_pkg::SET_FULL) ? gcm_pkg::LEAD_FULL : gcm_pkg::LEAD_SMALL;
    d3     = (set3 == gcm_pkg::SET_FULL) ? gcm_pkg::LEAD_FULL : gcm_pkg::LEAD_SMALL;
  end

  // Quotient estimate, low by at most one
  assign prod = PROD_BITS'(amt1) * PROD_BITS'(recip1);

  // Raw remainder, below twice the denomination
  always_comb begin
    qd = q0_2 * AMOUNT_BITS'(d2);
  end

  // Final correction step
  always_comb begin
    corr = r0_3 >= gcm_pkg::REM_BITS'(d3);
    q    = q0_3 + AMOUNT_BITS'(corr);
    r    = corr ? (r0_3 - gcm_pkg::REM_BITS'(d3)) : r0_3;
  end

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= load;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Data pipeline
  always_ff @(posedge clk) begin
    if (load) begin
      amt1 <= amount;
      set1 <= coin_set;
    end
    amt2 <= amt1;
    q0_2 <= AMOUNT_BITS'(prod >> gcm_pkg::RECIP_SHIFT);
    set2 <= set1;
    q0_3 <= q0_2;
    r0_3 <= gcm_pkg::REM_BITS'(amt2 - qd);
    set3 <= set2;
  end

  assign active   = v1 | v2 | v3;
  assign rest_vld = v3;
  assign rest     = gcm_pkg::REST_BITS'(r);

  // Lead result
  always_comb begin
    res = '0;
    if (v3 && (q != '0)) begin
      res.strobe = 1'b1;
      res.denom  = d3;
      res.count  = gcm_pkg::COUNT_BITS'(q);
      res.last   = (r == '0);
    end
  end

endmodule

// ----- src/gcm_cell.sv -----
module gcm_cell #(
  parameter int unsigned DENOM = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  logic [gcm_pkg::REST_BITS-1:0] in_rest,
  output logic                          vld,
  output logic [gcm_pkg::REST_BITS-1:0] rest_after,
  output gcm_pkg::result_t              res
);

  localparam logic [gcm_pkg::REST_BITS:0] ONE_D = (gcm_pkg::REST_BITS + 1)'(DENOM);
  localparam logic [gcm_pkg::REST_BITS:0] TWO_D = (gcm_pkg::REST_BITS + 1)'(2 * DENOM);

  logic [gcm_pkg::REST_BITS-1:0] rest;
  logic                          take1;
  logic                          take2;
  logic [1:0]                    cnt;

  // Held remainder for this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rest <= in_rest;
  end

  // Count is 0, 1 or 2: the remainder is below 2.5 times this denomination
  always_comb begin
    take1 = (gcm_pkg::REST_BITS + 1)'(rest) >= ONE_D;
    take2 = (gcm_pkg::REST_BITS + 1)'(rest) >= TWO_D;
    priority if (take2) begin
      cnt        = 2'd2;
      rest_after = rest - gcm_pkg::REST_BITS'(TWO_D);
    end else if (take1) begin
      cnt        = 2'd1;
      rest_after = rest - gcm_pkg::REST_BITS'(ONE_D);
    end else begin
      cnt        = 2'd0;
      rest_after = rest;
    end
  end

  // Result of this stage
  always_comb begin
    res = '0;
    if (vld && take1) begin
      res.strobe = 1'b1;
      res.denom  = gcm_pkg::DENOM_BITS'(DENOM);
      res.count  = gcm_pkg::COUNT_BITS'(cnt);
      res.last   = (rest_after == '0);
    end
  end

endmodule

// ----- src/greedy_change_maker.sv -----
// Greedy change maker: splits an amount in cents into denominations,
// largest first, and gives one result per denomination with a nonzero count.
// Command channel: amount_cents is taken at a clock edge with start high and
// busy low. Results appear on denomination, count and last, each valid for
// exactly one cycle while result_strobe is high; last marks the final result
// of an amount. A zero amount gives no results. The receiver cannot stall.
// cfg_we / cfg_wdata write the coin set (0: coins 200..1, 1: 50000..1);
// write it only while busy is low.
// Timing: a three-stage lead divider (reciprocal multiply, back-multiply,
// one correction) handles the largest denomination of the set, then the
// remainder walks a row of 14 compare cells, one cell per cycle. Each result
// is registered before it reaches the outputs; busy stays high until the
// amount has left the last cell, so a new amount is taken only after that.
// Reset (rst, synchronous) clears the pipeline and selects coin set 0.
module greedy_change_maker #(
  parameter int AMOUNT_BITS = gcm_pkg::AMOUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [AMOUNT_BITS-1:0]          amount_cents,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  output logic                            result_strobe,
  output logic [gcm_pkg::DENOM_BITS-1:0]  denomination,
  output logic [gcm_pkg::COUNT_BITS-1:0]  count,
  output logic                            last
);

  localparam int NCELL = gcm_pkg::CHAIN_CELLS;

  gcm_pkg::coin_set_t            coin_set;
  logic                          accept;
  logic                          div_active;
  logic                          div_vld;
  logic [gcm_pkg::REST_BITS-1:0] div_rest;

  logic [gcm_pkg::REST_BITS-1:0] link_rest [NCELL+1];
  logic                          link_vld  [NCELL+1];
  gcm_pkg::result_t              src       [NCELL+1];
  logic [NCELL-1:0]              cell_vld;
  gcm_pkg::result_t              res_any;

  // Coin set register
  always_ff @(posedge clk) begin
    if (rst) begin
      coin_set <= gcm_pkg::SET_COINS;
    end else if (cfg_we) begin
      coin_set <= gcm_pkg::coin_set_t'(cfg_wdata);
    end
  end

  assign accept = start && !busy;
  assign busy   = div_active || (cell_vld != '0);

  // Lead division
  gcm_lead_div #(
    .AMOUNT_BITS(AMOUNT_BITS)
  ) u_lead (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .amount   (amount_cents),
    .coin_set (coin_set),
    .active   (div_active),
    .rest_vld (div_vld),
    .rest     (div_rest),
    .res      (src[0])
  );

  assign link_vld[0]  = div_vld;
  assign link_rest[0] = div_rest;

  // Row of compare cells
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    gcm_cell #(
      .DENOM(gcm_pkg::CHAIN_DENOM[i])
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_vld     (link_vld[i]),
      .in_rest    (link_rest[i]),
      .vld        (link_vld[i+1]),
      .rest_after (link_rest[i+1]),
      .res        (src[i+1])
    );
    assign cell_vld[i] = link_vld[i+1];
  end

  // Only one stage holds the transaction, so results merge by OR
  always_comb begin
    res_any = '0;
    for (int i = 0; i <= NCELL; i++) begin
      res_any = res_any | src[i];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= res_any.strobe;
    end
  end

  always_ff @(posedge clk) begin
    denomination <= res_any.denom;
    count        <= res_any.count;
    last         <= res_any.last;
  end

endmodule
